/* design/tcp_cct_pkg.sv */
// ----------------------------------------------------------------------------
// tcp_cct_pkg
// Shared types, codes and constants of the TCP client connection tracker.
// ----------------------------------------------------------------------------
package tcp_cct_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned NUM_W    = 32;
  localparam int unsigned FLAGS_W  = 8;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned STATE_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [NUM_W-1:0] PASSIVE_SEQ_RESET = 32'd2071998;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_IP    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PASSIVE_SEQ = 1'b1;

  // TCP flag bytes, matched exactly
  localparam logic [FLAGS_W-1:0] FLAG_FIN     = 8'h01;
  localparam logic [FLAGS_W-1:0] FLAG_SYN     = 8'h02;
  localparam logic [FLAGS_W-1:0] FLAG_ACK     = 8'h10;
  localparam logic [FLAGS_W-1:0] FLAG_SYN_ACK = 8'h12;
  localparam logic [FLAGS_W-1:0] FLAG_FIN_ACK = 8'h11;
  localparam logic [FLAGS_W-1:0] FLAG_PSH_ACK = 8'h18;
  localparam logic [FLAGS_W-1:0] FLAG_NONE    = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_SEGMENT    = 3'd0,
    OP_CONNECT    = 3'd1,
    OP_SEND       = 3'd2,
    OP_DISCONNECT = 3'd3,
    OP_TIMEOUT    = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 3'd0,
    STS_ALREADY   = 3'd1,
    STS_NOT_CONN  = 3'd2,
    STS_IGNORED   = 3'd3,
    STS_CONNECTED = 3'd4,
    STS_CLOSED    = 3'd5,
    STS_SEND_FAIL = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'b0001,
    ST_SYN_SENT  = 4'b0010,
    ST_CONNECTED = 4'b0100,
    ST_AWAIT_ACK = 4'b1000
  } conn_state_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  seg_dest_ip;
    logic [FLAGS_W-1:0] seg_flags;
    logic [NUM_W-1:0]   seg_seq;
    logic [NUM_W-1:0]   seg_ack;
    logic [LEN_W-1:0]   seg_payload_len;
    logic [NUM_W-1:0]   start_seq;
    logic [LEN_W-1:0]   send_len;
  } item_t;

  // one decided item: its reply (one or a pair) and the state update
  typedef struct packed {
    logic               emit;
    logic [FLAGS_W-1:0] flags;
    logic [NUM_W-1:0]   seq;
    logic [NUM_W-1:0]   ack;
    logic [LEN_W-1:0]   len;
    status_t            status;
    logic               pair;      // ACK first, then the stored flags
    conn_state_t        state_next;
    logic [NUM_W-1:0]   seq_next;
    logic [NUM_W-1:0]   ack_next;
  } decision_t;

  function automatic logic [STATE_W-1:0] encode_state(conn_state_t s);
    logic [STATE_W-1:0] code;
    case (s)
      ST_IDLE:      code = 2'd0;
      ST_SYN_SENT:  code = 2'd1;
      ST_CONNECTED: code = 2'd2;
      ST_AWAIT_ACK: code = 2'd3;
      default:      code = 2'd0;
    endcase
    return code;
  endfunction

endpackage

/* design/tcp_cct_engine.sv */
// ----------------------------------------------------------------------------
// tcp_cct_engine
// Decides the reply, status and state update for one registered item.
// ----------------------------------------------------------------------------
module tcp_cct_engine (
  input  tcp_cct_pkg::item_t             item,
  input  tcp_cct_pkg::conn_state_t       conn_state,
  input  logic [tcp_cct_pkg::NUM_W-1:0]  our_seq,
  input  logic [tcp_cct_pkg::NUM_W-1:0]  our_ack,
  input  logic [tcp_cct_pkg::ADDR_W-1:0] local_ip,
  input  logic [tcp_cct_pkg::NUM_W-1:0]  passive_seq,
  output tcp_cct_pkg::decision_t         dec
);
  import tcp_cct_pkg::*;

  logic [NUM_W-1:0] our_seq_inc;
  logic [NUM_W-1:0] seg_seq_inc;
  logic [NUM_W-1:0] seg_seq_end;

  assign our_seq_inc = our_seq + 32'd1;
  assign seg_seq_inc = item.seg_seq + 32'd1;
  assign seg_seq_end = item.seg_seq + {{(NUM_W-LEN_W){1'b0}}, item.seg_payload_len};

  always_comb begin
    dec            = '0;
    dec.flags      = FLAG_NONE;
    dec.status     = STS_IGNORED;
    dec.state_next = conn_state;
    dec.seq_next   = our_seq;
    dec.ack_next   = our_ack;

    case (op_t'(item.op))
      OP_SEGMENT: begin
        if (item.seg_dest_ip == local_ip) begin
          case (item.seg_flags)
            FLAG_SYN_ACK: begin
              if ((conn_state == ST_SYN_SENT || conn_state == ST_CONNECTED) &&
                  item.seg_ack == our_seq_inc) begin
                dec.seq_next   = our_seq_inc;
                dec.ack_next   = seg_seq_inc;
                dec.state_next = ST_CONNECTED;
                dec.emit       = 1'b1;
                dec.flags      = FLAG_ACK;
                dec.seq        = item.seg_ack;
                dec.ack        = seg_seq_inc;
                dec.status     = STS_CONNECTED;
              end
            end
            FLAG_SYN: begin
              // passive open: answer without touching our state
              dec.emit   = 1'b1;
              dec.flags  = FLAG_SYN_ACK;
              dec.seq    = passive_seq;
              dec.ack    = seg_seq_inc;
              dec.status = STS_OK;
            end
            FLAG_ACK: begin
              if (conn_state == ST_AWAIT_ACK) begin
                dec.seq_next   = item.seg_ack;
                dec.ack_next   = item.seg_seq;
                dec.state_next = ST_CONNECTED;
                dec.status     = STS_OK;
              end
            end
            FLAG_FIN_ACK: begin
              dec.emit   = 1'b1;
              dec.pair   = 1'b1;
              dec.flags  = FLAG_FIN_ACK;
              dec.seq    = item.seg_ack;
              dec.ack    = seg_seq_inc;
              dec.status = STS_OK;
              if (item.seg_ack == our_seq || item.seg_ack == our_seq_inc) begin
                dec.state_next = ST_IDLE;
                dec.status     = STS_CLOSED;
              end
            end
            FLAG_PSH_ACK: begin
              if (conn_state == ST_CONNECTED && item.seg_seq == our_ack) begin
                dec.seq_next = item.seg_ack;
                dec.ack_next = seg_seq_end;
                dec.emit     = 1'b1;
                dec.flags    = FLAG_PSH_ACK;
                dec.seq      = item.seg_ack;
                dec.ack      = seg_seq_end;
                dec.status   = STS_OK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      OP_CONNECT: begin
        if (conn_state == ST_CONNECTED) begin
          dec.status = STS_ALREADY;
        end else begin
          dec.seq_next   = item.start_seq;
          dec.state_next = ST_SYN_SENT;
          dec.emit       = 1'b1;
          dec.flags      = FLAG_SYN;
          dec.seq        = item.start_seq;
          dec.status     = STS_OK;
        end
      end
      OP_SEND: begin
        if (conn_state != ST_CONNECTED) begin
          dec.status = STS_NOT_CONN;
        end else begin
          dec.state_next = ST_AWAIT_ACK;
          dec.emit       = 1'b1;
          dec.flags      = FLAG_PSH_ACK;
          dec.seq        = our_seq;
          dec.ack        = our_ack;
          dec.len        = item.send_len;
          dec.status     = STS_OK;
        end
      end
      OP_DISCONNECT: begin
        if (conn_state == ST_CONNECTED) begin
          dec.emit   = 1'b1;
          dec.flags  = FLAG_FIN_ACK;
          dec.seq    = our_seq;
          dec.ack    = our_ack;
          dec.status = STS_OK;
        end else begin
          dec.status = STS_NOT_CONN;
        end
      end
      OP_TIMEOUT: begin
        if (conn_state == ST_AWAIT_ACK) begin
          dec.state_next = ST_CONNECTED;
          dec.status     = STS_SEND_FAIL;
        end else if (conn_state == ST_SYN_SENT) begin
          dec.state_next = ST_IDLE;
          dec.status     = STS_NOT_CONN;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/tcp_client_connection_tracker.sv */
// ----------------------------------------------------------------------------
// tcp_client_connection_tracker
// Single-connection TCP client tracker: commands and received headers in,
// reply headers and status out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one command or one received
//   segment header per transfer. Output channel (out_valid / out_stall)
//   carries result items; last marks the final result of an input item.
//   An item is registered on input, decided against the connection state
//   once the result register can take it, and its result is registered in
//   the result register, from which it transfers when out_stall is low.
//   Throughput is one item per cycle while out_stall stays low and no pair
//   is showing. A FIN-ACK segment gives two results (ACK then FIN-ACK) from
//   one output register; the next item waits until the second is taken.
//   When out_stall is high the result register holds; the item already in
//   the input register waits and in_stall rises, so at most one item sits
//   behind a stalled result.
//   Reset (rst, synchronous) empties both registers, sets the state to idle,
//   sequence and ack numbers to zero, local_ip to zero and the passive
//   initial sequence number to its default.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next edge and are expected only while the block is idle.
// ----------------------------------------------------------------------------
module tcp_client_connection_tracker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tcp_cct_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcp_cct_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tcp_cct_pkg::OP_W-1:0]       op,
  input  logic [tcp_cct_pkg::ADDR_W-1:0]     seg_dest_ip,
  input  logic [tcp_cct_pkg::FLAGS_W-1:0]    seg_flags,
  input  logic [tcp_cct_pkg::NUM_W-1:0]      seg_seq,
  input  logic [tcp_cct_pkg::NUM_W-1:0]      seg_ack,
  input  logic [tcp_cct_pkg::LEN_W-1:0]      seg_payload_len,
  input  logic [tcp_cct_pkg::NUM_W-1:0]      start_seq,
  input  logic [tcp_cct_pkg::LEN_W-1:0]      send_len,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               emit_segment,
  output logic [tcp_cct_pkg::FLAGS_W-1:0]    out_flags,
  output logic [tcp_cct_pkg::NUM_W-1:0]      out_seq,
  output logic [tcp_cct_pkg::NUM_W-1:0]      out_ack,
  output logic [tcp_cct_pkg::LEN_W-1:0]      out_len,
  output logic [tcp_cct_pkg::STATUS_W-1:0]   status,
  output logic [tcp_cct_pkg::STATE_W-1:0]    conn_state_out,
  output logic                               last
);
  import tcp_cct_pkg::*;

  // configuration
  logic [ADDR_W-1:0] local_ip;
  logic [NUM_W-1:0]  passive_seq;

  // connection state
  conn_state_t       conn_state;
  logic [NUM_W-1:0]  our_seq;
  logic [NUM_W-1:0]  our_ack;

  // input register
  logic              in_q_valid;
  item_t             in_q;

  // result register
  decision_t         res_q;
  logic              phase;     // second result of a pair is showing

  decision_t         dec;
  logic              out_take;
  logic              out_done;
  logic              fire;

  tcp_cct_engine u_engine (
    .item        (in_q),
    .conn_state  (conn_state),
    .our_seq     (our_seq),
    .our_ack     (our_ack),
    .local_ip    (local_ip),
    .passive_seq (passive_seq),
    .dec         (dec)
  );

  assign out_take = out_valid && !out_stall;
  assign out_done = out_take && (!res_q.pair || phase);
  assign fire     = in_q_valid && (!out_valid || out_done);
  assign in_stall = in_q_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_ip    <= '0;
      passive_seq <= PASSIVE_SEQ_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LOCAL_IP:    local_ip    <= cfg_data;
        REG_PASSIVE_SEQ: passive_seq <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (fire) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q.op              <= op;
      in_q.seg_dest_ip     <= seg_dest_ip;
      in_q.seg_flags       <= seg_flags;
      in_q.seg_seq         <= seg_seq;
      in_q.seg_ack         <= seg_ack;
      in_q.seg_payload_len <= seg_payload_len;
      in_q.start_seq       <= start_seq;
      in_q.send_len        <= send_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      conn_state <= ST_IDLE;
      our_seq    <= '0;
      our_ack    <= '0;
      out_valid  <= 1'b0;
      phase      <= 1'b0;
    end else begin
      if (fire) begin
        conn_state <= dec.state_next;
        our_seq    <= dec.seq_next;
        our_ack    <= dec.ack_next;
        out_valid  <= 1'b1;
        phase      <= 1'b0;
      end else if (out_done) begin
        out_valid  <= 1'b0;
        phase      <= 1'b0;
      end else if (out_take) begin
        phase      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_q <= dec;
    end
  end

  // a pair shows a bare ACK first, then the stored FIN-ACK
  assign emit_segment   = res_q.emit;
  assign out_flags      = (res_q.pair && !phase) ? FLAG_ACK : res_q.flags;
  assign out_seq        = res_q.seq;
  assign out_ack        = res_q.ack;
  assign out_len        = res_q.len;
  assign status         = res_q.status;
  assign conn_state_out = encode_state(res_q.state_next);
  assign last           = !res_q.pair || phase;

endmodule

/* verif/tcp_client_connection_tracker_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcp_client_connection_tracker_test
// Self-checking bench for the TCP client connection tracker. A queue-fed
// driver sends commands and segment headers in random bursts. A predictor
// tracks the connection on every input transfer and queues the replies it
// should cause. A monitor checks each output transfer against those replies,
// field by field, while the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tcp_client_connection_tracker_test;
  import tcp_cct_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;  // cycles with no transfer at all
  localparam int unsigned HOLD_CYCLES = 400;

  typedef enum logic [STATE_W-1:0] {
    CS_IDLE, CS_SYN_SENT, CS_CONNECTED, CS_AWAIT_ACK
  } link_state_t;

  // fields patched from the tracked connection when the item is presented
  typedef enum logic [2:0] {
    FIX_NONE, FIX_SYNACK, FIX_FIN_SEQ, FIX_FIN_NEXT, FIX_PSH
  } fix_t;

  typedef struct {
    item_t it;
    fix_t  fix;
  } backlog_entry_t;

  typedef struct packed {
    logic               emit;
    logic [FLAGS_W-1:0] flags;
    logic [NUM_W-1:0]   seq;
    logic [NUM_W-1:0]   ack;
    logic [LEN_W-1:0]   len;
    status_t            status;
    link_state_t        state;
    logic               fin;
  } reply_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       op = '0;
  logic [ADDR_W-1:0]     seg_dest_ip = '0;
  logic [FLAGS_W-1:0]    seg_flags = '0;
  logic [NUM_W-1:0]      seg_seq = '0;
  logic [NUM_W-1:0]      seg_ack = '0;
  logic [LEN_W-1:0]      seg_payload_len = '0;
  logic [NUM_W-1:0]      start_seq = '0;
  logic [LEN_W-1:0]      send_len = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  emit_segment;
  logic [FLAGS_W-1:0]    out_flags;
  logic [NUM_W-1:0]      out_seq;
  logic [NUM_W-1:0]      out_ack;
  logic [LEN_W-1:0]      out_len;
  logic [STATUS_W-1:0]   status;
  logic [STATE_W-1:0]    conn_state_out;
  logic                  last;

  tcp_client_connection_tracker i_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .op, .seg_dest_ip, .seg_flags, .seg_seq, .seg_ack,
    .seg_payload_len, .start_seq, .send_len,
    .out_valid, .out_stall, .emit_segment, .out_flags, .out_seq, .out_ack,
    .out_len, .status, .conn_state_out, .last
  );

  // tracked copy of the connection and registers
  link_state_t      trk_state = CS_IDLE;
  logic [NUM_W-1:0] trk_seq = '0;
  logic [NUM_W-1:0] trk_ack = '0;
  logic [NUM_W-1:0] cfg_local_ip = '0;
  logic [NUM_W-1:0] cfg_passive_seq = PASSIVE_SEQ_RESET;

  backlog_entry_t cmd_backlog[$];
  reply_t         due_replies[$];
  int unsigned    queued_total = 0;
  int unsigned    accepted_total = 0;
  int unsigned    results_seen = 0;
  int unsigned    error_count = 0;

  item_t          cur_item;
  int unsigned    burst_left = 0;
  int unsigned    gap_left = 0;
  logic           sender_steady = 1'b0;
  logic           hold_request = 1'b0;
  logic           hold_done = 1'b0;
  int unsigned    hold_left = 0;
  int unsigned    stall_mode = 0;
  int unsigned    mode_left = 0;
  int unsigned    quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < 40)
      $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                results_seen, name, got, want));
  endtask

  function automatic void push_reply(input logic emit, input logic [FLAGS_W-1:0] flags,
                                     input logic [NUM_W-1:0] seq,
                                     input logic [NUM_W-1:0] ack,
                                     input logic [LEN_W-1:0] len,
                                     input status_t st, input logic fin);
    reply_t r;
    r.emit   = emit;
    r.flags  = flags;
    r.seq    = seq;
    r.ack    = ack;
    r.len    = len;
    r.status = st;
    r.state  = trk_state;
    r.fin    = fin;
    due_replies.push_back(r);
  endfunction

  // Advances the tracked connection by one accepted item, queues its replies.
  function automatic void track_connection(input item_t it);
    status_t st;
    accepted_total++;
    case (it.op)
      OP_SEGMENT: begin
        if (it.seg_dest_ip != cfg_local_ip) begin
          push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_IGNORED, 1'b1);
        end else if (it.seg_flags == FLAG_SYN_ACK &&
                     (trk_state == CS_SYN_SENT || trk_state == CS_CONNECTED) &&
                     it.seg_ack == trk_seq + 1) begin
          trk_seq   = trk_seq + 1;
          trk_ack   = it.seg_seq + 1;
          trk_state = CS_CONNECTED;
          push_reply(1'b1, FLAG_ACK, it.seg_ack, it.seg_seq + 1, '0, STS_CONNECTED, 1'b1);
        end else if (it.seg_flags == FLAG_SYN) begin
          push_reply(1'b1, FLAG_SYN_ACK, cfg_passive_seq, it.seg_seq + 1, '0, STS_OK, 1'b1);
        end else if (it.seg_flags == FLAG_ACK && trk_state == CS_AWAIT_ACK) begin
          trk_seq   = it.seg_ack;
          trk_ack   = it.seg_seq;
          trk_state = CS_CONNECTED;
          push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_OK, 1'b1);
        end else if (it.seg_flags == FLAG_FIN_ACK) begin
          st = STS_OK;
          if (it.seg_ack == trk_seq || it.seg_ack == trk_seq + 1) begin
            trk_state = CS_IDLE;
            st = STS_CLOSED;
          end
          push_reply(1'b1, FLAG_ACK, it.seg_ack, it.seg_seq + 1, '0, st, 1'b0);
          push_reply(1'b1, FLAG_FIN_ACK, it.seg_ack, it.seg_seq + 1, '0, st, 1'b1);
        end else if (it.seg_flags == FLAG_PSH_ACK && trk_state == CS_CONNECTED &&
                     it.seg_seq == trk_ack) begin
          trk_seq = it.seg_ack;
          trk_ack = it.seg_seq + NUM_W'(it.seg_payload_len);
          push_reply(1'b1, FLAG_PSH_ACK, trk_seq, trk_ack, '0, STS_OK, 1'b1);
        end else begin
          push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_IGNORED, 1'b1);
        end
      end
      OP_CONNECT: begin
        if (trk_state == CS_CONNECTED) begin
          push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_ALREADY, 1'b1);
        end else begin
          trk_seq   = it.start_seq;
          trk_state = CS_SYN_SENT;
          push_reply(1'b1, FLAG_SYN, trk_seq, '0, '0, STS_OK, 1'b1);
        end
      end
      OP_SEND: begin
        if (trk_state != CS_CONNECTED) begin
          push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_NOT_CONN, 1'b1);
        end else begin
          trk_state = CS_AWAIT_ACK;
          push_reply(1'b1, FLAG_PSH_ACK, trk_seq, trk_ack, it.send_len, STS_OK, 1'b1);
        end
      end
      OP_DISCONNECT: begin
        if (trk_state == CS_CONNECTED)
          push_reply(1'b1, FLAG_FIN_ACK, trk_seq, trk_ack, '0, STS_OK, 1'b1);
        else
          push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_NOT_CONN, 1'b1);
      end
      OP_TIMEOUT: begin
        if (trk_state == CS_AWAIT_ACK) begin
          trk_state = CS_CONNECTED;
          push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_SEND_FAIL, 1'b1);
        end else if (trk_state == CS_SYN_SENT) begin
          trk_state = CS_IDLE;
          push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_NOT_CONN, 1'b1);
        end else begin
          push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_IGNORED, 1'b1);
        end
      end
      default: push_reply(1'b0, FLAG_NONE, '0, '0, '0, STS_IGNORED, 1'b1);
    endcase
  endfunction

  // ---------------- stimulus helpers ----------------

  function automatic logic [NUM_W-1:0] any_num();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return {{(NUM_W-1){1'b1}}, 1'b0};
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] any_len();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return LEN_W'($urandom_range(1, 64));
      default: return LEN_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // unused number and length fields stay random so their input bits toggle
  function automatic item_t blank_item(input logic [OP_W-1:0] code);
    item_t it;
    it.op              = code;
    it.seg_dest_ip     = cfg_local_ip;
    it.seg_flags       = FLAG_NONE;
    it.seg_seq         = any_num();
    it.seg_ack         = any_num();
    it.seg_payload_len = any_len();
    it.start_seq       = any_num();
    it.send_len        = any_len();
    return it;
  endfunction

  function automatic item_t seg_item(input logic [FLAGS_W-1:0] flags);
    item_t it;
    it = blank_item(OP_SEGMENT);
    it.seg_flags = flags;
    return it;
  endfunction

  task automatic enqueue(input item_t it, input fix_t fix);
    backlog_entry_t e;
    e.it  = it;
    e.fix = fix;
    cmd_backlog.push_back(e);
    queued_total++;
  endtask

  task automatic noise();
    item_t it;
    if ($urandom_range(0, 1) == 0)
      it = blank_item(OP_SEGMENT);
    else
      it = blank_item(OP_W'($urandom_range(0, 2**OP_W - 1)));
    case ($urandom_range(0, 7))
      0: it.seg_flags = FLAG_SYN;
      1: it.seg_flags = FLAG_ACK;
      2: it.seg_flags = FLAG_SYN_ACK;
      3: it.seg_flags = FLAG_FIN_ACK;
      4: it.seg_flags = FLAG_PSH_ACK;
      5: it.seg_flags = FLAG_FIN;
      6: it.seg_flags = FLAG_NONE;
      default: it.seg_flags = FLAGS_W'($urandom());
    endcase
    if ($urandom_range(0, 6) == 0)
      it.seg_dest_ip = $urandom();
    enqueue(it, FIX_NONE);
  endtask

  // one client connection: open, exchange data, maybe close
  task automatic session();
    enqueue(blank_item(OP_CONNECT), FIX_NONE);
    if ($urandom_range(0, 9) == 0) begin
      enqueue(blank_item(OP_TIMEOUT), FIX_NONE);
    end else begin
      enqueue(seg_item(FLAG_SYN_ACK), FIX_SYNACK);
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(0, 9))
          0, 1, 2: enqueue(seg_item(FLAG_PSH_ACK), FIX_PSH);
          3, 4: begin
            enqueue(blank_item(OP_SEND), FIX_NONE);
            case ($urandom_range(0, 3))
              0: enqueue(blank_item(OP_TIMEOUT), FIX_NONE);
              1: ;
              default: enqueue(seg_item(FLAG_ACK), FIX_NONE);
            endcase
          end
          5: enqueue(blank_item(OP_DISCONNECT), FIX_NONE);
          6: enqueue(blank_item(OP_CONNECT), FIX_NONE);
          7: enqueue(seg_item(FLAG_SYN), FIX_NONE);
          8: enqueue(seg_item(FLAG_SYN_ACK), FIX_SYNACK);
          default: noise();
        endcase
      end
      case ($urandom_range(0, 3))
        0: enqueue(seg_item(FLAG_FIN_ACK), FIX_FIN_SEQ);
        1: enqueue(seg_item(FLAG_FIN_ACK), FIX_FIN_NEXT);
        2: enqueue(seg_item(FLAG_FIN_ACK), FIX_NONE);
        default: ;
      endcase
    end
  endtask

  task automatic traffic(input int unsigned count);
    int unsigned goal;
    goal = queued_total + count;
    while (queued_total < goal) begin
      if ($urandom_range(0, 9) < 7)
        session();
      else
        noise();
    end
  endtask

  // sender pause: everything accepted and every reply seen
  task automatic drain();
    while (accepted_total != queued_total || due_replies.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_LOCAL_IP)
      cfg_local_ip = val;
    else
      cfg_passive_seq = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic directed();
    item_t it;
    enqueue(blank_item(OP_TIMEOUT), FIX_NONE);
    enqueue(blank_item(OP_SEND), FIX_NONE);
    enqueue(blank_item(OP_DISCONNECT), FIX_NONE);
    enqueue(seg_item(FLAG_ACK), FIX_NONE);
    enqueue(seg_item(FLAG_SYN), FIX_NONE);
    enqueue(seg_item(FLAG_SYN_ACK), FIX_SYNACK);   // idle: no handshake open
    it = blank_item(OP_CONNECT);
    it.start_seq = '1;
    enqueue(it, FIX_NONE);
    enqueue(blank_item(OP_TIMEOUT), FIX_NONE);     // SYN sent back to idle
    it.start_seq = '0;
    enqueue(it, FIX_NONE);
    it.start_seq = '1;                             // reconnect from SYN sent
    enqueue(it, FIX_NONE);
    enqueue(seg_item(FLAG_SYN_ACK), FIX_NONE);     // wrong ack number
    it = seg_item(FLAG_SYN_ACK);
    it.seg_seq = '1;                               // both numbers wrap
    enqueue(it, FIX_SYNACK);
    enqueue(blank_item(OP_CONNECT), FIX_NONE);
    enqueue(seg_item(FLAG_SYN_ACK), FIX_SYNACK);   // re-sync while connected
    it = seg_item(FLAG_PSH_ACK);
    it.seg_payload_len = '1;
    enqueue(it, FIX_PSH);
    enqueue(seg_item(FLAG_PSH_ACK), FIX_NONE);     // out of order
    it = blank_item(OP_SEND);
    it.send_len = '1;
    enqueue(it, FIX_NONE);
    enqueue(seg_item(FLAG_PSH_ACK), FIX_PSH);      // awaiting ACK: dropped
    enqueue(blank_item(OP_TIMEOUT), FIX_NONE);
    it.send_len = '0;
    enqueue(it, FIX_NONE);
    enqueue(seg_item(FLAG_ACK), FIX_NONE);
    enqueue(blank_item(OP_DISCONNECT), FIX_NONE);
    it = seg_item(FLAG_SYN);
    it.seg_dest_ip = ~cfg_local_ip;
    enqueue(it, FIX_NONE);
    it = seg_item(FLAG_NONE);
    it.seg_flags = '1;
    enqueue(it, FIX_NONE);
    enqueue(seg_item(FLAG_FIN_ACK), FIX_NONE);     // FIN with foreign ack
    enqueue(seg_item(FLAG_FIN_ACK), FIX_FIN_NEXT);
    for (int c = int'(OP_TIMEOUT) + 1; c < 2**OP_W; c++)
      enqueue(blank_item(OP_W'(c)), FIX_NONE);
  endtask

  // ---------------- driver ----------------

  always @(posedge clk) begin : drive_proc
    logic           offer;
    backlog_entry_t nxt;
    offer = in_valid;
    if (rst) begin
      offer = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_connection(cur_item);
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left != 0 && !sender_steady) begin
          gap_left <= gap_left - 1;
        end else if (cmd_backlog.size() != 0) begin
          nxt = cmd_backlog.pop_front();
          case (nxt.fix)
            FIX_SYNACK:   nxt.it.seg_ack = trk_seq + 1;
            FIX_FIN_SEQ:  nxt.it.seg_ack = trk_seq;
            FIX_FIN_NEXT: nxt.it.seg_ack = trk_seq + 1;
            FIX_PSH:      nxt.it.seg_seq = trk_ack;
            default: ;
          endcase
          cur_item = nxt.it;
          op              <= cur_item.op;
          seg_dest_ip     <= cur_item.seg_dest_ip;
          seg_flags       <= cur_item.seg_flags;
          seg_seq         <= cur_item.seg_seq;
          seg_ack         <= cur_item.seg_ack;
          seg_payload_len <= cur_item.seg_payload_len;
          start_seq       <= cur_item.start_seq;
          send_len        <= cur_item.send_len;
          offer = 1'b1;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(0, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
    in_valid <= offer;
  end

  // ---------------- receiver stall ----------------

  always @(posedge clk) begin : stall_proc
    logic hold;
    hold = 1'b0;
    if (rst) begin
      hold = 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      hold = 1'b1;
    end else if (hold_request && !hold_done) begin
      // long back-pressure so the block fills up and stalls its input
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      hold = 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: hold = 1'b0;
        1: hold = ($urandom_range(0, 3) == 0);
        2: hold = ($urandom_range(0, 9) < 6);
        default: hold = ~out_stall;
      endcase
    end
    out_stall <= hold;
  end

  // ---------------- monitor ----------------

  always @(posedge clk) begin : monitor_proc
    reply_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_replies.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending, status %0d",
                                  results_seen, status));
      end else begin
        want = due_replies.pop_front();
        check_field("emit_segment", 32'(emit_segment), 32'(want.emit));
        check_field("out_flags", 32'(out_flags), 32'(want.flags));
        check_field("out_seq", out_seq, want.seq);
        check_field("out_ack", out_ack, want.ack);
        check_field("out_len", 32'(out_len), 32'(want.len));
        check_field("status", 32'(status), 32'(want.status));
        check_field("conn_state_out", 32'(conn_state_out), 32'(want.state));
        check_field("last", 32'(last), 32'(want.fin));
      end
      results_seen++;
    end
  end

  // ---------------- watchdog ----------------

  always @(posedge clk) begin : watchdog_proc
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tcp_client_connection_tracker_test NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------- test sequence ----------------

  initial begin : main_proc
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    directed();
    drain();

    write_reg(REG_LOCAL_IP, '1);
    write_reg(REG_PASSIVE_SEQ, '0);
    traffic(300);
    drain();

    // back-pressure phase: sender offers without gaps during the long hold
    write_reg(REG_LOCAL_IP, $urandom());
    write_reg(REG_PASSIVE_SEQ, '1);
    sender_steady <= 1'b1;
    hold_request  <= 1'b1;
    traffic(300);
    drain();
    sender_steady <= 1'b0;

    write_reg(REG_LOCAL_IP, $urandom());
    write_reg(REG_PASSIVE_SEQ, $urandom());
    traffic(350);
    drain();

    write_reg(REG_LOCAL_IP, '0);
    write_reg(REG_PASSIVE_SEQ, $urandom());
    traffic(300);
    drain();

    repeat (8) @(posedge clk);
    if (due_replies.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_replies.size()));
    if (error_count == 0)
      $display("tcp_client_connection_tracker_test OK");
    else
      $display("tcp_client_connection_tracker_test NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
design/tcp_cct_pkg.sv
design/tcp_cct_engine.sv
design/tcp_client_connection_tracker.sv
verif/tcp_client_connection_tracker_test.sv
